FILE: src/tfps_pkg.sv
// ----------------------------------------------------------------------------
// tfps_pkg
// Shared types, widths and constants of the tape-following PID steering block.
// ----------------------------------------------------------------------------
package tfps_pkg;

  // field widths
  localparam int ADC_BITS        = 12;
  localparam int ERROR_FRAC_BITS = 14;
  localparam int ERR_W           = ERROR_FRAC_BITS + 2;
  localparam int D_W             = ERR_W + 1;
  localparam int GAIN_W          = 16;
  localparam int STEER_W         = 12;
  localparam int MODE_W          = 2;
  localparam int INTEG_W         = 32;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_STEER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_MAX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_MIN    = 3'd5;

  // register reset values
  localparam logic [STEER_W-1:0] CENTER_STEER_RST = STEER_W'(246);
  localparam logic [STEER_W-1:0] STEER_MAX_RST    = STEER_W'(490);
  localparam logic [STEER_W-1:0] STEER_MIN_RST    = STEER_W'(82);

  // sensor thresholds with hysteresis
  localparam logic [ADC_BITS-1:0] THR_L_FROM_WHITE = ADC_BITS'(380);
  localparam logic [ADC_BITS-1:0] THR_L_TO_WHITE   = ADC_BITS'(340);
  localparam logic [ADC_BITS-1:0] THR_R_FROM_WHITE = ADC_BITS'(260);
  localparam logic [ADC_BITS-1:0] THR_R_TO_WHITE   = ADC_BITS'(220);

  // error of plus and minus one in fixed point
  localparam logic signed [ERR_W-1:0] ERR_ONE       = ERR_W'(2 ** ERROR_FRAC_BITS);
  localparam logic signed [ERR_W-1:0] ERR_MINUS_ONE = -ERR_ONE;

  // serial divider
  localparam int QUO_W = ERROR_FRAC_BITS + 1;
  localparam int REM_W = ADC_BITS + 2;
  localparam int DCNT_W = $clog2(QUO_W);

  // serial multiply-accumulate
  localparam int ACC_STEPS = INTEG_W;
  localparam int ACC_SHIFT = 8 + ERROR_FRAC_BITS;
  localparam int HI_BITS   = ACC_STEPS - ACC_SHIFT;
  localparam int T_W       = GAIN_W + 2;
  localparam int P_W       = T_W + 2;
  localparam int ST_W      = P_W + HI_BITS;
  localparam int MCNT_W    = $clog2(ACC_STEPS);

  // motor mode codes
  localparam logic [MODE_W-1:0] MODE_NORMAL      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PIVOT_LEFT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PIVOT_RIGHT = 2'd2;

  // error source codes from the sensor front end
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_HOLD  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MINUS = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PLUS  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RATIO = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ZERO  = 3'd4;

  typedef struct packed {
    logic [ADC_BITS-1:0] left_sample;
    logic [ADC_BITS-1:0] right_sample;
    logic                clear_integral;
  } in_word_t;

  typedef struct packed {
    logic [STEER_W-1:0]      steering;
    logic [MODE_W-1:0]       motor_mode;
    logic signed [ERR_W-1:0] error_value;
  } out_word_t;

  // front end result handed to the divider and error select
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic                neg;
    logic [ADC_BITS-1:0] mag;
    logic [ADC_BITS:0]   den;
    logic                clear_integral;
  } front_t;

endpackage

FILE: src/tfps_front.sv
// ----------------------------------------------------------------------------
// tfps_front
// Sensor thresholds with hysteresis, white flags, and the excess numerator
// and denominator for the ratio error.
// ----------------------------------------------------------------------------
module tfps_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  tfps_pkg::in_word_t sample,
  output tfps_pkg::front_t  prep
);
  import tfps_pkg::*;

  logic                l_white;
  logic                r_white;
  logic [ADC_BITS-1:0] thr_l;
  logic [ADC_BITS-1:0] thr_r;
  logic                lw;
  logic                rw;
  logic [ADC_BITS-1:0] le;
  logic [ADC_BITS-1:0] re;
  front_t              prep_next;

  // thresholds follow the previous flag
  always_comb begin
    thr_l = l_white ? THR_L_FROM_WHITE : THR_L_TO_WHITE;
    thr_r = r_white ? THR_R_FROM_WHITE : THR_R_TO_WHITE;
    lw    = sample.left_sample < thr_l;
    rw    = sample.right_sample < thr_r;
    le    = sample.left_sample - thr_l;
    re    = sample.right_sample - thr_r;
  end

  // excess difference and sum, and which error applies
  always_comb begin
    prep_next.neg            = le < re;
    prep_next.mag            = (le < re) ? (re - le) : (le - re);
    prep_next.den            = {1'b0, le} + {1'b0, re};
    prep_next.clear_integral = sample.clear_integral;
    priority if (lw && rw) begin
      prep_next.kind = KIND_HOLD;
    end else if (lw) begin
      prep_next.kind = KIND_MINUS;
    end else if (rw) begin
      prep_next.kind = KIND_PLUS;
    end else if (prep_next.den == '0) begin
      prep_next.kind = KIND_ZERO;
    end else begin
      prep_next.kind = KIND_RATIO;
    end
  end

  // white flags
  always_ff @(posedge clk) begin
    if (rst) begin
      l_white <= 1'b1;
      r_white <= 1'b1;
    end else if (accept) begin
      l_white <= lw;
      r_white <= rw;
    end
  end

  // registered front end result
  always_ff @(posedge clk) begin
    if (accept) begin
      prep <= prep_next;
    end
  end

endmodule

FILE: src/tfps_div.sv
// ----------------------------------------------------------------------------
// tfps_div
// Restoring divider, one quotient bit a cycle: mag * 2^F / den with mag <= den.
// ----------------------------------------------------------------------------
module tfps_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [tfps_pkg::ADC_BITS-1:0]    mag,
  input  logic [tfps_pkg::ADC_BITS:0]      den,
  output logic                             done,
  output logic [tfps_pkg::QUO_W-1:0]       quo
);
  import tfps_pkg::*;

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  den_x;
  logic [REM_W-1:0]  mag_x;
  logic              bit_first;
  logic              bit_step;

  // compare and subtract for the integer bit and for each fraction bit
  always_comb begin
    den_x     = {1'b0, den};
    mag_x     = {2'b00, mag};
    rem_sh    = {rem[REM_W-2:0], 1'b0};
    bit_first = mag_x >= den_x;
    bit_step  = rem_sh >= den_x;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(ERROR_FRAC_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= bit_first ? (mag_x - den_x) : mag_x;
      quo <= QUO_W'(bit_first);
    end else if (busy) begin
      rem <= bit_step ? (rem_sh - den_x) : rem_sh;
      quo <= {quo[QUO_W-2:0], bit_step};
    end
  end

endmodule

FILE: src/tfps_mac.sv
// ----------------------------------------------------------------------------
// tfps_mac
// Bit-serial multiply-accumulate of the three PID terms plus the mid point,
// floor shift by 8+F, and the steering clamp.
// ----------------------------------------------------------------------------
module tfps_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [tfps_pkg::GAIN_W-1:0]    kp_gain,
  input  logic signed [tfps_pkg::GAIN_W-1:0]    kd_gain,
  input  logic signed [tfps_pkg::GAIN_W-1:0]    ki_gain,
  input  logic [tfps_pkg::STEER_W-1:0]          center_steer,
  input  logic [tfps_pkg::STEER_W-1:0]          steer_max,
  input  logic [tfps_pkg::STEER_W-1:0]          steer_min,
  input  logic signed [tfps_pkg::ERR_W-1:0]     err,
  input  logic signed [tfps_pkg::D_W-1:0]       diff,
  input  logic signed [tfps_pkg::INTEG_W-1:0]   integ,
  output logic                                  done,
  output logic [tfps_pkg::STEER_W-1:0]          steering
);
  import tfps_pkg::*;

  logic                    run;
  logic                    fin;
  logic [MCNT_W-1:0]       cnt;
  logic [ACC_STEPS-1:0]    e_sh;
  logic [ACC_STEPS-1:0]    d_sh;
  logic [ACC_STEPS-1:0]    i_sh;
  logic signed [P_W-1:0]   p_acc;
  logic [HI_BITS-1:0]      hi;
  logic signed [T_W-1:0]   t_sum;
  logic signed [P_W-1:0]   t_ext;
  logic signed [P_W-1:0]   mid_ext;
  logic signed [P_W-1:0]   sum;
  logic signed [ST_W-1:0]  st;
  logic signed [ST_W-1:0]  max_ext;
  logic signed [ST_W-1:0]  min_ext;

  // partial products of this bit position
  always_comb begin
    t_sum = (e_sh[0] ? $signed({{(T_W-GAIN_W){kp_gain[GAIN_W-1]}}, kp_gain}) : '0)
          + (d_sh[0] ? $signed({{(T_W-GAIN_W){kd_gain[GAIN_W-1]}}, kd_gain}) : '0)
          + (i_sh[0] ? $signed({{(T_W-GAIN_W){ki_gain[GAIN_W-1]}}, ki_gain}) : '0);
    t_ext   = $signed({{(P_W-T_W){t_sum[T_W-1]}}, t_sum});
    mid_ext = (cnt == MCNT_W'(ACC_SHIFT)) ?
              $signed({{(P_W-STEER_W){1'b0}}, center_steer}) : '0;
    // sign bit position carries negative weight
    if (cnt == MCNT_W'(ACC_STEPS - 1)) begin
      sum = p_acc - t_ext + mid_ext;
    end else begin
      sum = p_acc + t_ext + mid_ext;
    end
  end

  // shifted result and clamp bounds
  always_comb begin
    st      = $signed({p_acc, hi});
    max_ext = $signed({{(ST_W-STEER_W){1'b0}}, steer_max});
    min_ext = $signed({{(ST_W-STEER_W){1'b0}}, steer_min});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == MCNT_W'(ACC_STEPS - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        done <= 1'b1;
      end
    end
  end

  // operand shift registers, accumulator and low result bits
  always_ff @(posedge clk) begin
    if (start) begin
      e_sh  <= {{(ACC_STEPS-ERR_W){err[ERR_W-1]}}, err};
      d_sh  <= {{(ACC_STEPS-D_W){diff[D_W-1]}}, diff};
      i_sh  <= integ;
      p_acc <= '0;
    end else if (run) begin
      e_sh  <= e_sh >> 1;
      d_sh  <= d_sh >> 1;
      i_sh  <= i_sh >> 1;
      p_acc <= sum >>> 1;
      hi    <= {sum[0], hi[HI_BITS-1:1]};
    end
  end

  // clamp, upper bound first
  always_ff @(posedge clk) begin
    if (fin) begin
      priority if (st >= max_ext) begin
        steering <= steer_max;
      end else if (st <= min_ext) begin
        steering <= steer_min;
      end else begin
        steering <= st[STEER_W-1:0];
      end
    end
  end

endmodule

FILE: src/tape_follow_pid_steering.sv
// ----------------------------------------------------------------------------
// tape_follow_pid_steering
// Line-following PID steering: tape sensor thresholds, ratio error, saturating
// integral, clamped steering command and pivot motor mode.
// ----------------------------------------------------------------------------
// One word in gives one word out, and the block takes one word at a time:
// a result passes through the front end register, the restoring divider
// (one quotient bit a cycle), the error select, the bit-serial
// multiply-accumulate over the integral width and the clamp before it
// reaches the output register. The next input word is taken on the cycle
// after the previous result is loaded into the output register, even while
// that result is still stalled. Configuration writes go through cfg_we /
// cfg_index / cfg_data and apply at once; indexes beyond the six registers
// are ignored.
module tape_follow_pid_steering (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tfps_pkg::in_word_t                 in_word,
  output logic                               out_valid,
  input  logic                               out_stall,
  output tfps_pkg::out_word_t                out_word,
  input  logic                               cfg_we,
  input  logic [tfps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tfps_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tfps_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_ERR  = 3'd3;
  localparam logic [2:0] ST_MAC  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]                state;
  logic [2:0]                state_next;
  logic                      accept;

  logic signed [GAIN_W-1:0]  kp_gain;
  logic signed [GAIN_W-1:0]  kd_gain;
  logic signed [GAIN_W-1:0]  ki_gain;
  logic [STEER_W-1:0]        center_steer;
  logic [STEER_W-1:0]        steer_max;
  logic [STEER_W-1:0]        steer_min;

  front_t                    prep;
  logic                      div_done;
  logic [QUO_W-1:0]          quo;
  logic                      mac_done;
  logic [STEER_W-1:0]        steering;

  logic signed [ERR_W-1:0]   prev_error;
  logic signed [INTEG_W-1:0] integral;
  logic signed [ERR_W-1:0]   err_q;
  logic [MODE_W-1:0]         mode_q;

  logic signed [ERR_W-1:0]   err_next;
  logic signed [ERR_W-1:0]   quo_ext;
  logic signed [D_W-1:0]     diff_next;
  logic signed [INTEG_W-1:0] integ_base;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integral_next;
  logic [MODE_W-1:0]         mode_next;

  assign accept   = in_valid && !in_stall;
  assign in_stall = state != ST_IDLE;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain      <= '0;
      kd_gain      <= '0;
      ki_gain      <= '0;
      center_steer <= CENTER_STEER_RST;
      steer_max    <= STEER_MAX_RST;
      steer_min    <= STEER_MIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KP_GAIN:      kp_gain      <= $signed(cfg_data[GAIN_W-1:0]);
        CFG_KD_GAIN:      kd_gain      <= $signed(cfg_data[GAIN_W-1:0]);
        CFG_KI_GAIN:      ki_gain      <= $signed(cfg_data[GAIN_W-1:0]);
        CFG_CENTER_STEER: center_steer <= cfg_data[STEER_W-1:0];
        CFG_STEER_MAX:    steer_max    <= cfg_data[STEER_W-1:0];
        CFG_STEER_MIN:    steer_min    <= cfg_data[STEER_W-1:0];
        default: ;
      endcase
    end
  end

  // sensor front end
  tfps_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .sample (in_word),
    .prep   (prep)
  );

  // ratio divider
  tfps_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_LOAD),
    .mag   (prep.mag),
    .den   (prep.den),
    .done  (div_done),
    .quo   (quo)
  );

  // error select
  always_comb begin
    quo_ext = $signed({{(ERR_W-QUO_W){1'b0}}, quo});
    unique case (prep.kind)
      KIND_HOLD:  err_next = prev_error;
      KIND_MINUS: err_next = ERR_MINUS_ONE;
      KIND_PLUS:  err_next = ERR_ONE;
      KIND_RATIO: err_next = prep.neg ? -quo_ext : quo_ext;
      default:    err_next = '0;
    endcase
  end

  // derivative, saturating integral and motor mode
  always_comb begin
    diff_next  = $signed({err_next[ERR_W-1], err_next})
               - $signed({prev_error[ERR_W-1], prev_error});
    integ_base = prep.clear_integral ? '0 : integral;
    integ_sum  = $signed({integ_base[INTEG_W-1], integ_base})
               + $signed({{(INTEG_W+1-ERR_W){err_next[ERR_W-1]}}, err_next});
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integral_next = integ_sum[INTEG_W] ? $signed({1'b1, {(INTEG_W-1){1'b0}}})
                                         : $signed({1'b0, {(INTEG_W-1){1'b1}}});
    end else begin
      integral_next = integ_sum[INTEG_W-1:0];
    end
    priority if (err_next == ERR_ONE) begin
      mode_next = MODE_PIVOT_RIGHT;
    end else if (err_next == ERR_MINUS_ONE) begin
      mode_next = MODE_PIVOT_LEFT;
    end else begin
      mode_next = MODE_NORMAL;
    end
  end

  // loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
      integral   <= '0;
    end else if (state == ST_ERR) begin
      prev_error <= err_next;
      integral   <= integral_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ERR) begin
      err_q  <= err_next;
      mode_q <= mode_next;
    end
  end

  // PID sum and clamp
  tfps_mac u_mac (
    .clk          (clk),
    .rst          (rst),
    .start        (state == ST_ERR),
    .kp_gain      (kp_gain),
    .kd_gain      (kd_gain),
    .ki_gain      (ki_gain),
    .center_steer (center_steer),
    .steer_max    (steer_max),
    .steer_min    (steer_min),
    .err          (err_next),
    .diff         (diff_next),
    .integ        (integral_next),
    .done         (mac_done),
    .steering     (steering)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_ERR;
      ST_ERR:  state_next = ST_MAC;
      ST_MAC:  if (mac_done) state_next = ST_DONE;
      ST_DONE: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      out_word.steering    <= steering;
      out_word.motor_mode  <= mode_q;
      out_word.error_value <= err_q;
    end
  end

`ifndef NO_ASSERTIONS
  // divider and accumulator only finish in the state that waits for them
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_mac_done_in_mac: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> state == ST_MAC)
    else $error("accumulator finished outside the accumulate state");

  // a new result only comes from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("output word loaded outside the done state");

  // ratio error stays within plus or minus one
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.error_value <= ERR_ONE)
               && (out_word.error_value >= ERR_MINUS_ONE))
    else $error("error value out of range");
`endif

endmodule

FILE: sim/tape_follow_pid_steering_tb.sv
// ----------------------------------------------------------------------------
// tape_follow_pid_steering_tb
// Self-checking bench for the tape-following PID steering block. A directed
// list of sensor words and register writes runs first, then randomized sensor
// traffic under several gain and clamp settings and three pacing modes. Every
// steering word out is compared field by field with its typed directed row or
// a bench model of sensor hysteresis, ratio error, integral and clamped PID sum.
// ----------------------------------------------------------------------------
module tape_follow_pid_steering_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tfps_pkg::*;

  localparam int ITEMS_PER_SLOT = 117;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 60;
  localparam int REPORT_LIMIT   = 10;
  localparam longint SUM_HI     = 2147483647;
  localparam longint SUM_LO     = -SUM_HI - 1;

  // register indexes past the last register, ignored by the block
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef enum bit {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    int                    lsamp;
    int                    rsamp;
    bit                    clr;
    bit                    typed;
    int                    steer;
    logic [MODE_W-1:0]     mode;
    int                    err;
  } plan_row_t;

  localparam int PLAN_LEN = 41;

  // directed list, run at the reset register values first
  plan_row_t plan [PLAN_LEN] = '{
    // both white at reset holds the zero error
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 0, 0, 0, 1, 246, MODE_NORMAL, 0},
    // only right white, then only left white
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 4095, 0, 1, 1, 246, MODE_PIVOT_RIGHT, int'(ERR_ONE)},
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 0, 4095, 0, 1, 246, MODE_PIVOT_LEFT,
      int'(ERR_MINUS_ONE)},
    // held error of minus one keeps the pivot
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 0, 0, 0, 1, 246, MODE_PIVOT_LEFT, int'(ERR_MINUS_ONE)},
    // just under the from-white thresholds
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 379, 259, 0, 0, 0, MODE_NORMAL, 0},
    // exactly on the thresholds: both excesses zero
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 380, 260, 0, 1, 246, MODE_NORMAL, 0},
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 340, 220, 0, 1, 246, MODE_NORMAL, 0},
    // just under the to-white thresholds
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 339, 219, 0, 1, 246, MODE_NORMAL, 0},
    // ratio with one excess zero lands on plus and minus one
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 400, 260, 0, 1, 246, MODE_PIVOT_RIGHT, int'(ERR_ONE)},
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 340, 300, 0, 1, 246, MODE_PIVOT_LEFT,
      int'(ERR_MINUS_ONE)},
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 4095, 4095, 1, 0, 0, MODE_NORMAL, 0},
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 2730, 1365, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 1365, 2730, 1, 0, 0, MODE_NORMAL, 0},
    // extreme gains, KD at its most negative, wide clamps, upper data bits set on a 12-bit register
    '{ROW_CFG, CFG_KP_GAIN, 16'h7FFF, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_CFG, CFG_KD_GAIN, 16'h8000, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_CFG, CFG_KI_GAIN, 16'h7FFF, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_CFG, CFG_CENTER_STEER, 16'hF800, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_CFG, CFG_STEER_MAX, 16'h0FFF, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_CFG, CFG_STEER_MIN, 16'h0000, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 4095, 0, 1, 0, 0, MODE_NORMAL, 0},
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 0, 4095, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 1000, 500, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 600, 900, 0, 0, 0, MODE_NORMAL, 0},
    // extreme gains, KD at its most positive, clamps collapsed to zero
    '{ROW_CFG, CFG_KP_GAIN, 16'h8000, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_CFG, CFG_KD_GAIN, 16'h7FFF, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_CFG, CFG_KI_GAIN, 16'h8000, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_CFG, CFG_CENTER_STEER, 16'h0FFF, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_CFG, CFG_STEER_MAX, 16'h0000, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_CFG, CFG_STEER_MIN, 16'h0000, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 700, 700, 1, 0, 0, MODE_NORMAL, 0},
    // lower clamp above upper clamp, plus writes to unused indexes
    '{ROW_CFG, CFG_KP_GAIN, 16'h0000, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_CFG, CFG_KD_GAIN, 16'h0000, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_CFG, CFG_KI_GAIN, 16'h0000, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_CFG, CFG_CENTER_STEER, 16'd2000, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_CFG, CFG_STEER_MAX, 16'd1000, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_CFG, CFG_STEER_MIN, 16'd3000, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_CFG, CFG_SPARE_B, 16'hFFFF, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_CFG, CFG_SPARE_A, 16'h1234, 0, 0, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 500, 300, 0, 0, 0, MODE_NORMAL, 0},
    '{ROW_WORD, CFG_KP_GAIN, 16'h0, 100, 4095, 0, 0, 0, MODE_NORMAL, 0}
  };

  // dut ports, inputs driven from time zero
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // pacing controls
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req_cnt  = 0;

  // output hold-off counters
  int unsigned hold_left = 0;
  int unsigned hold_seen = 0;

  // model registers, at their reset values
  logic signed [GAIN_W-1:0] gain_p      = '0;
  logic signed [GAIN_W-1:0] gain_d      = '0;
  logic signed [GAIN_W-1:0] gain_i      = '0;
  logic [STEER_W-1:0]       mid_setting = CENTER_STEER_RST;
  logic [STEER_W-1:0]       max_setting = STEER_MAX_RST;
  logic [STEER_W-1:0]       min_setting = STEER_MIN_RST;

  // model state
  logic                      sens_l_white = 1'b1;
  logic                      sens_r_white = 1'b1;
  logic signed [ERR_W-1:0]   last_err     = '0;
  logic signed [INTEG_W-1:0] err_sum      = '0;

  // steering words still owed by the block, oldest first
  out_word_t steer_cmd_q [$];
  int unsigned mismatch_cnt = 0;

  tape_follow_pid_steering u_dut (
    .clk,
    .rst,
    .in_valid,
    .in_stall,
    .in_word,
    .out_valid,
    .out_stall,
    .out_word,
    .cfg_we,
    .cfg_index,
    .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one sensor step: hysteresis, ratio error, integral, pid sum, clamp
  function automatic out_word_t pid_steer_step(input in_word_t w);
    logic [ADC_BITS-1:0] thr_l, thr_r;
    logic                l_white, r_white;
    longint              e, le, re, num, den, sum, d, acc, st;
    out_word_t           o;
    thr_l   = sens_l_white ? THR_L_FROM_WHITE : THR_L_TO_WHITE;
    thr_r   = sens_r_white ? THR_R_FROM_WHITE : THR_R_TO_WHITE;
    l_white = w.left_sample < thr_l;
    r_white = w.right_sample < thr_r;
    if (l_white && r_white) begin
      e = longint'(last_err);
    end else if (l_white) begin
      e = longint'(ERR_MINUS_ONE);
    end else if (r_white) begin
      e = longint'(ERR_ONE);
    end else begin
      le  = longint'(w.left_sample) - longint'(thr_l);
      re  = longint'(w.right_sample) - longint'(thr_r);
      num = le - re;
      den = le + re;
      if (den <= 0) begin
        e = 0;
      end else begin
        e = ((num < 0 ? -num : num) <<< ERROR_FRAC_BITS) / den;
        if (num < 0) e = -e;
      end
    end
    sens_l_white = l_white;
    sens_r_white = r_white;

    // saturating integral
    if (w.clear_integral) err_sum = '0;
    sum = longint'(err_sum) + e;
    if (sum > SUM_HI) sum = SUM_HI;
    if (sum < SUM_LO) sum = SUM_LO;
    err_sum = INTEG_W'(sum);

    d        = e - longint'(last_err);
    last_err = ERR_W'(e);

    // exact sum, floored back to whole steering steps
    acc = (longint'(mid_setting) <<< ACC_SHIFT) + longint'(gain_p) * e
        + longint'(gain_d) * d + longint'(gain_i) * longint'(err_sum);
    st  = acc >>> ACC_SHIFT;
    if (st >= longint'(max_setting)) begin
      o.steering = max_setting;
    end else if (st <= longint'(min_setting)) begin
      o.steering = min_setting;
    end else begin
      o.steering = STEER_W'(st);
    end
    if (e == longint'(ERR_ONE)) begin
      o.motor_mode = MODE_PIVOT_RIGHT;
    end else if (e == longint'(ERR_MINUS_ONE)) begin
      o.motor_mode = MODE_PIVOT_LEFT;
    end else begin
      o.motor_mode = MODE_NORMAL;
    end
    o.error_value = ERR_W'(e);
    return o;
  endfunction

  function automatic logic [GAIN_W-1:0] gain_draw();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // sensor pairs weighted toward the interesting regions
  function automatic in_word_t draw_sensor_word();
    in_word_t    w;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      w.left_sample  = ADC_BITS'($urandom_range(300, 1800));
      w.right_sample = ADC_BITS'($urandom_range(200, 1800));
    end else if (pick < 55) begin
      w.left_sample  = ADC_BITS'($urandom_range(330, 390));
      w.right_sample = ADC_BITS'($urandom_range(210, 270));
    end else if (pick < 70) begin
      if ($urandom_range(1)) begin
        w.left_sample  = ADC_BITS'($urandom_range(0, 339));
        w.right_sample = ADC_BITS'($urandom_range(261, 4095));
      end else begin
        w.left_sample  = ADC_BITS'($urandom_range(381, 4095));
        w.right_sample = ADC_BITS'($urandom_range(0, 219));
      end
    end else if (pick < 80) begin
      w.left_sample  = ADC_BITS'($urandom_range(0, 339));
      w.right_sample = ADC_BITS'($urandom_range(0, 219));
    end else begin
      w.left_sample  = ADC_BITS'($urandom);
      w.right_sample = ADC_BITS'($urandom);
    end
    w.clear_integral = ($urandom_range(7) == 0);
    return w;
  endfunction

  function automatic void log_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  // register write, one clock wide, mirrored into the model
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_KP_GAIN:      gain_p = data;
      CFG_KD_GAIN:      gain_d = data;
      CFG_KI_GAIN:      gain_i = data;
      CFG_CENTER_STEER: mid_setting = data[STEER_W-1:0];
      CFG_STEER_MAX:    max_setting = data[STEER_W-1:0];
      CFG_STEER_MIN:    min_setting = data[STEER_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // offer one sensor word, with random gaps ahead of it
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_exp);
    out_word_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    pred = pid_steer_step(w);
    steer_cmd_q.push_back(typed ? typed_exp : pred);
    @(negedge clk);
  endtask

  // stop offering and wait for every owed word
  task automatic wait_steer_drain();
    in_valid <= 1'b0;
    while (steer_cmd_q.size() != 0) @(negedge clk);
  endtask

  // output stall: random, or a long counted hold-off on request
  always @(negedge clk) begin : sink_pacing
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req_cnt != hold_seen) begin
      hold_seen = hold_req_cnt;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // compare each accepted word with the oldest owed one
  always @(posedge clk) begin : word_check
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (steer_cmd_q.size() == 0) begin
        log_mismatch($sformatf("unexpected word: steer=%0d mode=%0d err=%0d",
          out_word.steering, out_word.motor_mode, $signed(out_word.error_value)));
      end else begin
        want = steer_cmd_q.pop_front();
        if (out_word.steering !== want.steering || out_word.motor_mode !== want.motor_mode
            || out_word.error_value !== want.error_value) begin
          log_mismatch($sformatf(
            "word mismatch: want steer=%0d mode=%0d err=%0d, got steer=%0d mode=%0d err=%0d",
            want.steering, want.motor_mode, $signed(want.error_value),
            out_word.steering, out_word.motor_mode, $signed(out_word.error_value)));
        end
      end
    end
  end

  initial begin : stimulus
    in_word_t           w;
    out_word_t          typed_exp;
    logic [STEER_W-1:0] mid_v, max_v, min_v;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed list
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_steer_drain();
        cfg_write(plan[i].idx, plan[i].data);
      end else begin
        w.left_sample          = ADC_BITS'(plan[i].lsamp);
        w.right_sample         = ADC_BITS'(plan[i].rsamp);
        w.clear_integral       = plan[i].clr;
        typed_exp.steering     = STEER_W'(plan[i].steer);
        typed_exp.motor_mode   = plan[i].mode;
        typed_exp.error_value  = ERR_W'(plan[i].err);
        send_word(w, plan[i].typed, typed_exp);
      end
    end

    // random traffic: three pacing modes, four register settings each
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int slot = 0; slot < 4; slot++) begin
        wait_steer_drain();
        if (slot == 0) begin
          mid_v = $urandom_range(1) ? 12'hFFF : 12'h000;
          max_v = $urandom_range(1) ? 12'hFFF : 12'h000;
          min_v = $urandom_range(1) ? 12'hFFF : 12'h000;
        end else begin
          mid_v = STEER_W'($urandom_range(500, 3500));
          max_v = STEER_W'(int'(mid_v) + int'($urandom_range(0, 500)));
          min_v = STEER_W'(int'(mid_v) - int'($urandom_range(0, 500)));
        end
        cfg_write(CFG_KP_GAIN, gain_draw());
        cfg_write(CFG_KD_GAIN, gain_draw());
        cfg_write(CFG_KI_GAIN, gain_draw());
        cfg_write(CFG_CENTER_STEER, {4'($urandom), mid_v});
        cfg_write(CFG_STEER_MAX, {4'($urandom), max_v});
        cfg_write(CFG_STEER_MIN, {4'($urandom), min_v});
        for (int n = 0; n < ITEMS_PER_SLOT; n++) begin
          // sender pause until the block has emptied
          if (slot == 1 && n == 60) wait_steer_drain();
          // long output hold-off while words keep coming
          if (slot == 2 && n == 0) hold_req_cnt++;
          send_word(draw_sensor_word(), 1'b0, '0);
        end
      end
    end

    wait_steer_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && steer_cmd_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("timeout with %0d steering words still owed", steer_cmd_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: tape_follow_pid_steering.f
src/tfps_pkg.sv
src/tfps_front.sv
src/tfps_div.sv
src/tfps_mac.sv
src/tape_follow_pid_steering.sv
sim/tape_follow_pid_steering_tb.sv
